// File: hdl/cdstp_pkg.sv
// Shared types, constants and calendar tables for the calendar date stepper.
// Used by the channel interfaces, the divider, the top level and its checker.
// No dependencies.
`default_nettype none

package cdstp_pkg;

    localparam int FIRST_YEAR     = 1754;
    // Day number of 1 Jan 1754, counted from 1 Jan of year 1 (a Monday).
    localparam int SERIAL_FIRST   = 640270;
    localparam int WDAY_FIRST     = 1;
    localparam int DAYS_AHEAD_MAX = 33554431;
    localparam int MONTHS         = 12;
    localparam int QUADS_CENTURY  = 24;
    localparam int ERA_YEARS      = 400;
    localparam int CENTURY_YEARS  = 100;

    localparam int DAYS_ERA       = 146097;
    localparam int DAYS_CENTURY   = 36524;
    localparam int DAYS_QUAD      = 1461;
    localparam int DAYS_YEAR      = 365;
    localparam int DAYS_WEEK      = 7;

    localparam int DIV_W          = 18;

    typedef enum logic [1:0] {
        FN_LOAD,
        FN_STEP,
        FN_QUERY,
        FN_NONE
    } t_func;

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_EARLIER,
        ST_OVERFLOW
    } t_status;

    typedef enum logic [2:0] {
        DV_CENT,
        DV_ERA,
        DV_CENTURY,
        DV_QUAD,
        DV_YEAR,
        DV_WEEK
    } t_div_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_SER1,
        S_SER2,
        S_SER3,
        S_CHECK,
        S_STEPCHK,
        S_MWALK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [4:0]  day_in;
        logic [3:0]  month_in;
        logic [15:0] year_in;
        logic [19:0] step_days;
    } t_req_item;

    typedef struct packed {
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [15:0] cur_year;
        logic [2:0]  weekday;
        logic [24:0] days_ahead;
        logic [1:0]  status;
    } t_rsp_item;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] s;
        unique case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [DIV_W-1:0] divisor_of(input t_div_op op);
        logic [DIV_W-1:0] d;
        unique case (op)
            DV_CENT:    d = DIV_W'(CENTURY_YEARS);
            DV_ERA:     d = DIV_W'(DAYS_ERA);
            DV_CENTURY: d = DIV_W'(DAYS_CENTURY);
            DV_QUAD:    d = DIV_W'(DAYS_QUAD);
            DV_YEAR:    d = DIV_W'(DAYS_YEAR);
            DV_WEEK:    d = DIV_W'(DAYS_WEEK);
            default:    d = DIV_W'(DAYS_WEEK);
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: hdl/cdstp_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on cdstp_pkg for the payload structs.
`default_nettype none

interface cdstp_req_if;
    logic                  valid;
    logic                  ready;
    cdstp_pkg::t_req_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cdstp_rsp_if;
    logic                  valid;
    logic                  ready;
    cdstp_pkg::t_rsp_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/calendar_date_stepper.sv
// Gregorian date register with load, day stepping and days-ahead query; one request at a time.
// A query runs one division and the serial-number steps; a valid load runs the same and then a
// weekday division. A step in range runs four calendar divisions, the month walk and one weekday
// division; an unused function code gets its response without any division.
// A new request is taken only once the previous response has been accepted.
// Synchronous active-low reset sets the date to 1 Jan 1754, a Tuesday, with no response pending.
`default_nettype none

module calendar_date_stepper #(
    parameter int YEAR_BITS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    cdstp_req_if.sink    i_req,
    cdstp_rsp_if.source  o_rsp
);
    import cdstp_pkg::*;

    localparam int     SW   = YEAR_BITS + 10;
    localparam longint YMAX = (longint'(1) << YEAR_BITS) - 1;
    localparam longint LAST = 365 * YMAX + YMAX / 4 - YMAX / 100 + YMAX / 400 - 1;

    t_state                r_state, n_state;
    t_req_item             r_in, n_in;
    logic [SW-1:0]         r_acc, n_acc;
    logic [SW-1:0]         r_cur, n_cur;
    logic [4:0]            r_day, n_day;
    logic [3:0]            r_month, n_month;
    logic [YEAR_BITS-1:0]  r_year, n_year;
    logic [2:0]            r_wday, n_wday;
    t_div_op               r_divop, n_divop;
    logic [YEAR_BITS-1:0]  r_q100y, n_q100y;
    logic                  r_leap, n_leap;
    logic [YEAR_BITS-1:0]  r_yacc, n_yacc;
    logic [1:0]            r_q100, n_q100;
    logic [4:0]            r_q4, n_q4;
    logic [3:0]            r_mon, n_mon;
    logic [24:0]           r_ahead, n_ahead;
    t_status               r_status, n_status;
    t_rsp_item             r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    t_div_req              w_div_req;
    logic                  w_div_done;
    logic [SW-1:0]         w_quo;
    logic [DIV_W-1:0]      w_rem;

    logic                  w_ready;
    logic [YEAR_BITS-1:0]  w_yin;
    logic [YEAR_BITS-1:0]  w_p;
    logic                  w_valid;
    logic [SW-1:0]         w_diff;
    logic [1:0]            w_q100c;
    logic [SW-1:0]         w_rem100;
    logic [2:0]            w_q1c;
    logic [SW-1:0]         w_rem1;
    logic [4:0]            w_mlen;

    cdstp_div #(
        .SW(SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (r_acc),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    assign w_ready = (r_state == S_IDLE) && !r_out_valid;
    assign w_yin   = YEAR_BITS'(r_in.year_in);
    assign w_p     = w_yin - YEAR_BITS'(1);
    assign w_diff  = r_acc - r_cur;
    assign w_mlen  = month_len(r_mon, r_leap);

    assign w_valid = (32'(r_in.year_in) >= 32'(FIRST_YEAR))
                  && (32'(r_in.year_in) <= 32'(YMAX))
                  && (r_in.month_in >= 4'd1) && (r_in.month_in <= 4'(MONTHS))
                  && (r_in.day_in != 5'd0)
                  && (r_in.day_in <= month_len(r_in.month_in, r_leap));

    // The last day of a 400-year era and of a 4-year cycle make the quotient come out
    // one too large; fold it back into the remainder.
    assign w_q100c  = w_quo[2] ? 2'd3 : w_quo[1:0];
    assign w_rem100 = w_quo[2] ? SW'(w_rem) + SW'(DAYS_CENTURY) : SW'(w_rem);
    assign w_q1c    = w_quo[2] ? 3'd3 : w_quo[2:0];
    assign w_rem1   = w_quo[2] ? SW'(w_rem) + SW'(DAYS_YEAR) : SW'(w_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cur       <= SW'(SERIAL_FIRST);
            r_day       <= 5'd1;
            r_month     <= 4'd1;
            r_year      <= YEAR_BITS'(FIRST_YEAR);
            r_wday      <= 3'(WDAY_FIRST);
            r_divop     <= DV_CENT;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cur       <= n_cur;
            r_day       <= n_day;
            r_month     <= n_month;
            r_year      <= n_year;
            r_wday      <= n_wday;
            r_divop     <= n_divop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_acc    <= n_acc;
        r_q100y  <= n_q100y;
        r_leap   <= n_leap;
        r_yacc   <= n_yacc;
        r_q100   <= n_q100;
        r_q4     <= n_q4;
        r_mon    <= n_mon;
        r_ahead  <= n_ahead;
        r_status <= n_status;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_acc       = r_acc;
        n_cur       = r_cur;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_wday      = r_wday;
        n_divop     = r_divop;
        n_q100y     = r_q100y;
        n_leap      = r_leap;
        n_yacc      = r_yacc;
        n_q100      = r_q100;
        n_q4        = r_q4;
        n_mon       = r_mon;
        n_ahead     = r_ahead;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;

        w_div_req.start   = (r_state == S_LAUNCH);
        w_div_req.divisor = divisor_of(r_divop);

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid && w_ready) begin
                    n_in     = i_req.data;
                    n_status = ST_OK;
                    n_ahead  = '0;
                    unique case (t_func'(i_req.data.func))
                        FN_LOAD, FN_QUERY: begin
                            n_acc   = SW'(YEAR_BITS'(i_req.data.year_in));
                            n_divop = DV_CENT;
                            n_state = S_LAUNCH;
                        end
                        FN_STEP: begin
                            n_acc   = r_cur + SW'(i_req.data.step_days);
                            n_state = S_STEPCHK;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_LAUNCH: begin
                n_state = S_WAIT;
            end

            S_WAIT: begin
                if (w_div_done) begin
                    unique case (r_divop)
                        DV_CENT: begin
                            // Year split by 100 gives both the leap test and (year - 1) / 100.
                            n_leap  = (w_yin[1:0] == 2'b00)
                                   && ((w_rem != '0) || (w_quo[1:0] == 2'b00));
                            n_q100y = YEAR_BITS'(w_quo)
                                    - ((w_rem == '0) ? YEAR_BITS'(1) : YEAR_BITS'(0));
                            n_state = S_SER1;
                        end
                        DV_ERA: begin
                            n_yacc  = YEAR_BITS'(w_quo * SW'(ERA_YEARS));
                            n_acc   = SW'(w_rem);
                            n_divop = DV_CENTURY;
                            n_state = S_LAUNCH;
                        end
                        DV_CENTURY: begin
                            n_q100  = w_q100c;
                            n_yacc  = r_yacc + YEAR_BITS'(w_q100c) * YEAR_BITS'(CENTURY_YEARS);
                            n_acc   = w_rem100;
                            n_divop = DV_QUAD;
                            n_state = S_LAUNCH;
                        end
                        DV_QUAD: begin
                            n_q4    = w_quo[4:0];
                            n_yacc  = r_yacc + YEAR_BITS'({w_quo[4:0], 2'b00});
                            n_acc   = SW'(w_rem);
                            n_divop = DV_YEAR;
                            n_state = S_LAUNCH;
                        end
                        DV_YEAR: begin
                            n_yacc  = r_yacc + YEAR_BITS'(w_q1c) + YEAR_BITS'(1);
                            n_leap  = (w_q1c == 3'd3)
                                   && ((r_q4 != 5'(QUADS_CENTURY)) || (r_q100 == 2'd3));
                            n_acc   = w_rem1;
                            n_mon   = 4'd1;
                            n_state = S_MWALK;
                        end
                        DV_WEEK: begin
                            n_wday  = 3'(w_rem);
                            n_state = S_OUT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_SER1: begin
                n_acc   = SW'(w_p) * SW'(DAYS_YEAR);
                n_state = S_SER2;
            end

            S_SER2: begin
                n_acc   = r_acc + SW'(w_p >> 2) - SW'(r_q100y);
                n_state = S_SER3;
            end

            S_SER3: begin
                n_acc   = r_acc + SW'(r_q100y >> 2) + SW'(month_start(r_in.month_in))
                        + SW'((r_in.month_in > 4'd2) && r_leap)
                        + SW'(r_in.day_in) - SW'(1);
                n_state = S_CHECK;
            end

            S_CHECK: begin
                if (!w_valid) begin
                    n_status = ST_INVALID;
                    n_state  = S_OUT;
                end else if (t_func'(r_in.func) == FN_LOAD) begin
                    n_day   = r_in.day_in;
                    n_month = r_in.month_in;
                    n_year  = w_yin;
                    n_cur   = r_acc;
                    n_divop = DV_WEEK;
                    n_state = S_LAUNCH;
                end else if (r_acc < r_cur) begin
                    n_status = ST_EARLIER;
                    n_state  = S_OUT;
                end else begin
                    n_ahead = (64'(w_diff) > 64'(DAYS_AHEAD_MAX)) ? 25'(DAYS_AHEAD_MAX)
                                                                  : 25'(w_diff);
                    n_state = S_OUT;
                end
            end

            S_STEPCHK: begin
                if (r_acc > SW'(LAST)) begin
                    n_status = ST_OVERFLOW;
                    n_state  = S_OUT;
                end else begin
                    n_cur   = r_acc;
                    n_divop = DV_ERA;
                    n_state = S_LAUNCH;
                end
            end

            S_MWALK: begin
                if ((r_mon < 4'(MONTHS)) && (r_acc >= SW'(w_mlen))) begin
                    n_acc = r_acc - SW'(w_mlen);
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_day   = 5'(r_acc) + 5'd1;
                    n_month = r_mon;
                    n_year  = r_yacc;
                    n_acc   = r_cur;
                    n_divop = DV_WEEK;
                    n_state = S_LAUNCH;
                end
            end

            S_OUT: begin
                n_out.cur_day    = r_day;
                n_out.cur_month  = r_month;
                n_out.cur_year   = 16'(r_year);
                n_out.weekday    = r_wday;
                n_out.days_ahead = r_ahead;
                n_out.status     = r_status;
                n_out_valid      = 1'b1;
                n_state          = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_req.ready = w_ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

// File: hdl/cdstp_div.sv
// Shared constant divider for every calendar computation: reciprocal multiply, then one
// correction step. Depends on cdstp_pkg for the request struct, the divisors and widths.
`default_nettype none

module cdstp_div #(
    parameter int SW = 26
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  cdstp_pkg::t_div_req   i_req,
    input  wire  [SW-1:0]               i_dividend,
    output logic                        o_done,
    output logic [SW-1:0]               o_quo,
    output logic [cdstp_pkg::DIV_W-1:0] o_rem
);
    import cdstp_pkg::*;

    // The reciprocal is consumed PW bits per cycle, top slice first, so each product
    // stays narrow. A remainder phase and a correction phase follow the last slice, then done is raised.
    localparam int PW  = 16;
    localparam int NCH = (SW + PW - 1) / PW;
    localparam int MW  = NCH * PW;
    localparam int XW  = SW + MW;
    localparam int CW  = $clog2(NCH + 1);
    localparam int RW  = DIV_W + 1;

    // floor(2^SW / d) underestimates the quotient by at most one for any SW-bit dividend.
    localparam logic [MW-1:0] M_CENT    = MW'((longint'(1) << SW) / longint'(CENTURY_YEARS));
    localparam logic [MW-1:0] M_ERA     = MW'((longint'(1) << SW) / longint'(DAYS_ERA));
    localparam logic [MW-1:0] M_CENTURY = MW'((longint'(1) << SW) / longint'(DAYS_CENTURY));
    localparam logic [MW-1:0] M_QUAD    = MW'((longint'(1) << SW) / longint'(DAYS_QUAD));
    localparam logic [MW-1:0] M_YEAR    = MW'((longint'(1) << SW) / longint'(DAYS_YEAR));
    localparam logic [MW-1:0] M_WEEK    = MW'((longint'(1) << SW) / longint'(DAYS_WEEK));

    logic             r_busy;
    logic             r_rem_ph;
    logic             r_fix_ph;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [SW-1:0]    r_x;
    logic [MW-1:0]    r_m;
    logic [DIV_W-1:0] r_d;
    logic [XW-1:0]    r_prod;
    logic [SW-1:0]    r_q;
    logic [RW-1:0]    r_r;

    logic [MW-1:0]    w_recip;
    logic [XW-1:0]    w_part;
    logic [SW-1:0]    w_qest;
    logic [SW-1:0]    w_qd;
    logic             w_over;

    always_comb begin
        unique case (i_req.divisor)
            DIV_W'(CENTURY_YEARS): w_recip = M_CENT;
            DIV_W'(DAYS_ERA):      w_recip = M_ERA;
            DIV_W'(DAYS_CENTURY):  w_recip = M_CENTURY;
            DIV_W'(DAYS_QUAD):     w_recip = M_QUAD;
            DIV_W'(DAYS_YEAR):     w_recip = M_YEAR;
            default:               w_recip = M_WEEK;
        endcase
    end

    assign w_part = XW'(r_x * r_m[MW-1 -: PW]);
    assign w_qest = r_prod[2*SW-1:SW];
    assign w_qd   = SW'(w_qest * SW'(r_d));
    assign w_over = r_r >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_rem_ph <= 1'b0;
            r_fix_ph <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_rem_ph <= r_busy && (r_cnt == CW'(1)) && !i_req.start;
            r_fix_ph <= r_rem_ph;
            r_done   <= r_fix_ph;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NCH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= i_dividend;
            r_m    <= w_recip;
            r_d    <= i_req.divisor;
            r_prod <= '0;
        end else if (r_busy) begin
            r_prod <= (r_prod << PW) + w_part;
            r_m    <= r_m << PW;
        end
        if (r_rem_ph) begin
            r_q <= w_qest;
            r_r <= RW'(r_x - w_qd);
        end else if (r_fix_ph && w_over) begin
            r_q <= r_q + SW'(1);
            r_r <= r_r - {1'b0, r_d};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = DIV_W'(r_r);

endmodule

`default_nettype wire

// File: hdl/cdstp_chk.sv
// Port-level checker for the calendar date stepper, bound to the top level.
// Depends on cdstp_pkg for the response struct and status codes.
`default_nettype none

module cdstp_chk (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_req_valid,
    input wire                   i_req_ready,
    input wire                   i_rsp_valid,
    input wire                   i_rsp_ready,
    input wire cdstp_pkg::t_rsp_item i_rsp_data
);
    import cdstp_pkg::*;

    // A stalled response keeps its contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("response changed while stalled");

    // Only one request is in flight: no request is taken while a response waits.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request ready while a response is pending");

    // Every accepted request keeps the block busy for at least the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("ready right after an accepted request");

    // An error response carries no day count.
    a_err_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_data.status != ST_OK) |-> (i_rsp_data.days_ahead == '0))
        else $error("days_ahead set on an error response");

endmodule

bind calendar_date_stepper cdstp_chk u_cdstp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire

// File: verif/tb_calendar_date_stepper.sv
// Self-checking testbench for calendar_date_stepper: loads, day steps and days-ahead queries.
// Expected responses come from a day-number calendar kept in a small scoreboard class.
// Depends on cdstp_pkg, the channel interfaces in cdstp_if.sv and the top level.
`timescale 1ns / 1ps

module tb_calendar_date_stepper;

    import cdstp_pkg::*;

    localparam int unsigned YEAR_MAX       = 65535;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 200;
    localparam int unsigned RANDOM_TARGET  = 900;
    localparam int unsigned QUIET_TAIL     = 150;

    class date_scoreboard;
        bit [4:0]        day_q;
        bit [3:0]        mon_q;
        bit [15:0]       yr_q;
        longint unsigned first_day;
        longint unsigned last_day;
        t_rsp_item       expected_rsp[$];
        int unsigned     errors;
        int unsigned     checked;
        int unsigned     status_seen[4];

        function new();
            day_q     = 5'd1;
            mon_q     = 4'd1;
            yr_q      = 16'(FIRST_YEAR);
            first_day = day_number(FIRST_YEAR, 1, 1);
            last_day  = day_number(YEAR_MAX + 1, 1, 1) - 1;
            errors    = 0;
            checked   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        static function bit leap_year(longint unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        static function int unsigned month_days(int unsigned m, longint unsigned y);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        // Days elapsed since 1 Jan of year 1.
        static function longint unsigned day_number(longint unsigned y, int unsigned m,
                                                    int unsigned d);
            longint unsigned p;
            longint unsigned s;
            p = y - 1;
            s = 365 * p + p / 4 - p / 100 + p / 400;
            for (int unsigned k = 1; k < m; k++) s += month_days(k, y);
            return s + d - 1;
        endfunction

        static function void date_of(input longint unsigned n, output longint unsigned y,
                                     output int unsigned m, output int unsigned d);
            longint unsigned r;
            longint unsigned q400;
            longint unsigned q100;
            longint unsigned q4;
            longint unsigned q1;
            q400 = n / DAYS_ERA;
            r    = n % DAYS_ERA;
            q100 = r / DAYS_CENTURY;
            // The last day of a 400-year era belongs to the fourth century.
            if (q100 == 4) q100 = 3;
            r   -= q100 * DAYS_CENTURY;
            q4   = r / DAYS_QUAD;
            r    = r % DAYS_QUAD;
            q1   = r / DAYS_YEAR;
            if (q1 == 4) q1 = 3;
            r   -= q1 * DAYS_YEAR;
            y    = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
            m    = 1;
            while (m < 12 && r >= month_days(m, y)) begin
                r -= month_days(m, y);
                m++;
            end
            d = int'(r) + 1;
        endfunction

        static function bit date_ok(int unsigned d, int unsigned m, longint unsigned y);
            if (y < FIRST_YEAR || y > YEAR_MAX) return 1'b0;
            if (m < 1 || m > 12) return 1'b0;
            return d >= 1 && d <= month_days(m, y);
        endfunction

        function longint unsigned today();
            return day_number(yr_q, mon_q, day_q);
        endfunction

        function int unsigned outstanding();
            return expected_rsp.size();
        endfunction

        // Advances the calendar for one accepted request and queues the response it owes.
        function void note_request(t_req_item r);
            t_rsp_item       e;
            t_status         st;
            longint unsigned cur;
            longint unsigned tgt;
            longint unsigned diff;
            longint unsigned ny;
            int unsigned     nm;
            int unsigned     nd;
            st   = ST_OK;
            diff = 0;
            cur  = today();
            case (t_func'(r.func))
                FN_LOAD: begin
                    if (date_ok(r.day_in, r.month_in, r.year_in)) begin
                        day_q = r.day_in;
                        mon_q = r.month_in;
                        yr_q  = r.year_in;
                    end else begin
                        st = ST_INVALID;
                    end
                end
                FN_STEP: begin
                    tgt = cur + r.step_days;
                    if (tgt > last_day) begin
                        st = ST_OVERFLOW;
                    end else begin
                        date_of(tgt, ny, nm, nd);
                        yr_q  = ny[15:0];
                        mon_q = nm[3:0];
                        day_q = nd[4:0];
                    end
                end
                FN_QUERY: begin
                    if (!date_ok(r.day_in, r.month_in, r.year_in)) begin
                        st = ST_INVALID;
                    end else begin
                        tgt = day_number(r.year_in, r.month_in, r.day_in);
                        if (tgt < cur) begin
                            st = ST_EARLIER;
                        end else begin
                            diff = tgt - cur;
                            if (diff > DAYS_AHEAD_MAX) diff = DAYS_AHEAD_MAX;
                        end
                    end
                end
                default: ;
            endcase
            e.cur_day    = day_q;
            e.cur_month  = mon_q;
            e.cur_year   = yr_q;
            e.weekday    = 3'((today() - first_day + 1) % DAYS_WEEK);
            e.days_ahead = diff[24:0];
            e.status     = st;
            status_seen[st]++;
            expected_rsp.push_back(e);
        endfunction

        function void compare_field(string fld, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fld, want, got);
            end
        endfunction

        function void check_response(t_rsp_item got);
            t_rsp_item e;
            if (expected_rsp.size() == 0) begin
                errors++;
                $display("%0t: response with nothing expected: expected none, actual %p",
                         $time, got);
                return;
            end
            e = expected_rsp.pop_front();
            checked++;
            compare_field("cur_day",    e.cur_day,    got.cur_day);
            compare_field("cur_month",  e.cur_month,  got.cur_month);
            compare_field("cur_year",   e.cur_year,   got.cur_year);
            compare_field("weekday",    e.weekday,    got.weekday);
            compare_field("days_ahead", e.days_ahead, got.days_ahead);
            compare_field("status",     e.status,     got.status);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    cdstp_req_if req_if();
    cdstp_rsp_if rsp_if();

    calendar_date_stepper #(
        .YEAR_BITS(16)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    date_scoreboard sb;
    bit             idling_on;
    int unsigned    n_load;
    int unsigned    n_step;
    int unsigned    n_query;
    int unsigned    n_unused;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Holds valid high back to back unless a gap is drawn; valid drops only for gaps and pauses.
    task automatic send_request(input t_req_item item);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        sb.note_request(item);
    endtask

    task automatic issue(input t_func fn, input bit [4:0] d, input bit [3:0] m,
                         input bit [15:0] y, input bit [19:0] n);
        t_req_item item;
        item.func      = fn;
        item.day_in    = d;
        item.month_in  = m;
        item.year_in   = y;
        item.step_days = n;
        case (fn)
            FN_LOAD:  n_load++;
            FN_STEP:  n_step++;
            FN_QUERY: n_query++;
            default:  n_unused++;
        endcase
        send_request(item);
    endtask

    task automatic drain_responses();
        req_if.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic pick_date(output bit [4:0] d, output bit [3:0] m, output bit [15:0] y);
        int unsigned len;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: y = 16'($urandom_range(FIRST_YEAR, 2500));
            6, 7:             y = 16'($urandom_range(FIRST_YEAR, YEAR_MAX));
            default:          y = 16'($urandom_range(65000, YEAR_MAX));
        endcase
        m   = 4'($urandom_range(1, 12));
        len = date_scoreboard::month_days(m, y);
        // Month ends get extra weight since they are where the walk changes month.
        d   = ($urandom_range(0, 3) == 0) ? 5'(len) : 5'($urandom_range(1, len));
    endtask

    task automatic random_request();
        bit [4:0]        d;
        bit [3:0]        m;
        bit [15:0]       y;
        bit [19:0]       n;
        int unsigned     pick;
        longint unsigned tgt;
        longint unsigned ty;
        int unsigned     tm;
        int unsigned     td;
        d    = 5'($urandom);
        m    = 4'($urandom);
        y    = 16'($urandom);
        n    = 20'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            issue(FN_NONE, d, m, y, n);
        end else if (pick < 34) begin
            if ($urandom_range(0, 9) != 0) pick_date(d, m, y);
            issue(FN_LOAD, d, m, y, n);
        end else if (pick < 67) begin
            case ($urandom_range(0, 3))
                0:       n = 20'($urandom_range(0, 31));
                1:       n = 20'($urandom_range(0, 400));
                2:       n = 20'($urandom_range(0, 50000));
                default: ;
            endcase
            issue(FN_STEP, d, m, y, n);
        end else begin
            case ($urandom_range(0, 5))
                0: ;
                1: pick_date(d, m, y);
                default: begin
                    case ($urandom_range(0, 3))
                        0:       tgt = sb.today() + $urandom_range(0, 60);
                        1:       tgt = sb.today() + $urandom_range(0, 5000);
                        2:       tgt = sb.today() + $urandom_range(0, 3000000);
                        default: tgt = sb.today() - $urandom_range(1, 400);
                    endcase
                    if (tgt >= sb.first_day && tgt <= sb.last_day) begin
                        date_scoreboard::date_of(tgt, ty, tm, td);
                        y = ty[15:0];
                        m = tm[3:0];
                        d = td[4:0];
                    end else begin
                        pick_date(d, m, y);
                    end
                end
            endcase
            issue(FN_QUERY, d, m, y, n);
        end
    endtask

    initial begin : rsp_side
        int unsigned hold;
        hold = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) sb.check_response(rsp_if.data);
            if (hold != 0) begin
                rsp_if.ready <= 1'b0;
                hold--;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                rsp_if.ready <= 1'b0;
                hold = $urandom_range(1, 7) - 1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb_calendar_date_stepper NOT OK");
        $finish;
    end

    initial begin : stimulus
        int unsigned counted;
        sb        = new();
        idling_on = 1'b1;
        n_load    = 0;
        n_step    = 0;
        n_query   = 0;
        n_unused  = 0;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: leap rules, each kind of invalid date, month and year rollover,
        // earlier targets, the widest query, the longest step and stepping past the last year.
        issue(FN_QUERY, 5'd1,  4'd1,  16'd1754,  20'd0);
        issue(FN_STEP,  5'd0,  4'd0,  16'd0,     20'd0);
        issue(FN_NONE,  5'd31, 4'd15, 16'hFFFF,  20'hFFFFF);
        issue(FN_LOAD,  5'd29, 4'd2,  16'd2000,  20'd0);
        issue(FN_LOAD,  5'd29, 4'd2,  16'd1900,  20'd0);
        issue(FN_LOAD,  5'd30, 4'd2,  16'd2024,  20'd0);
        issue(FN_LOAD,  5'd0,  4'd5,  16'd2020,  20'd0);
        issue(FN_LOAD,  5'd31, 4'd4,  16'd2020,  20'd0);
        issue(FN_LOAD,  5'd1,  4'd0,  16'd2020,  20'd0);
        issue(FN_LOAD,  5'd1,  4'd13, 16'd2020,  20'd0);
        issue(FN_LOAD,  5'd1,  4'd15, 16'd2020,  20'd0);
        issue(FN_LOAD,  5'd31, 4'd12, 16'd1753,  20'd0);
        issue(FN_LOAD,  5'd28, 4'd2,  16'd2100,  20'd0);
        issue(FN_STEP,  5'd0,  4'd0,  16'd0,     20'd1);
        issue(FN_LOAD,  5'd31, 4'd12, 16'd1999,  20'd0);
        issue(FN_STEP,  5'd0,  4'd0,  16'd0,     20'd1);
        issue(FN_QUERY, 5'd1,  4'd1,  16'd1754,  20'd0);
        issue(FN_QUERY, 5'd31, 4'd2,  16'd2001,  20'd0);
        issue(FN_LOAD,  5'd1,  4'd1,  16'd1754,  20'd0);
        issue(FN_QUERY, 5'd31, 4'd12, 16'hFFFF,  20'd0);
        issue(FN_STEP,  5'd0,  4'd0,  16'd0,     20'hFFFFF);
        issue(FN_LOAD,  5'd31, 4'd12, 16'hFFFF,  20'd0);
        issue(FN_STEP,  5'd0,  4'd0,  16'd0,     20'd1);
        issue(FN_QUERY, 5'd31, 4'd12, 16'hFFFF,  20'd0);
        issue(FN_STEP,  5'd0,  4'd0,  16'd0,     20'd0);
        drain_responses();

        counted = 0;
        while (counted < RANDOM_TARGET) begin
            if (counted % 100 == 0) idling_on = ($urandom_range(0, 3) != 0);
            if (counted >= RANDOM_TARGET - QUIET_TAIL) idling_on = 1'b0;
            if (counted == RANDOM_TARGET / 2) drain_responses();
            counted = n_load + n_step + n_query;
            random_request();
            counted = n_load + n_step + n_query - 25 + 1;
        end
        req_if.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d loads, %0d steps, %0d queries and %0d unused-code requests.",
                 n_load, n_step, n_query, n_unused);
        $display("Responses checked: %0d; ok %0d, invalid %0d, earlier %0d, overflow %0d.",
                 sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_INVALID],
                 sb.status_seen[ST_EARLIER], sb.status_seen[ST_OVERFLOW]);
        if (sb.outstanding() != 0)
            $display("%0t: %0d expected responses never arrived", $time, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb_calendar_date_stepper OK");
        end else begin
            $display("tb_calendar_date_stepper NOT OK");
        end
        $finish;
    end

endmodule
